// ----- rtl/bfs_pkg.sv -----
// ----------------------------------------------------------------------------
// bfs_pkg
// Shared types, codes and helpers for the tape-language stepping core.
// ----------------------------------------------------------------------------
package bfs_pkg;

  // default store depths
  localparam int unsigned TapeDepthDefault = 32768;
  localparam int unsigned ProgDepthDefault = 4096;

  // command characters
  localparam logic [7:0] CHAR_RIGHT = 8'h3E;
  localparam logic [7:0] CHAR_LEFT  = 8'h3C;
  localparam logic [7:0] CHAR_INC   = 8'h2B;
  localparam logic [7:0] CHAR_DEC   = 8'h2D;
  localparam logic [7:0] CHAR_OUT   = 8'h2E;
  localparam logic [7:0] CHAR_IN    = 8'h2C;
  localparam logic [7:0] CHAR_OPEN  = 8'h5B;
  localparam logic [7:0] CHAR_CLOSE = 8'h5D;

  // executed command field when nothing ran
  localparam logic [3:0] EXEC_NONE = 4'd0;

  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_STEP    = 2'd1,
    REQ_RESTART = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_e;

  // stored 3-bit command codes
  typedef enum logic [2:0] {
    CMD_RIGHT = 3'd0,
    CMD_LEFT  = 3'd1,
    CMD_INC   = 3'd2,
    CMD_DEC   = 3'd3,
    CMD_OUT   = 3'd4,
    CMD_IN    = 3'd5,
    CMD_OPEN  = 3'd6,
    CMD_CLOSE = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_END       = 2'd1,
    ST_UNMATCHED = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE      = 4'd0,
    OP_CAPTURE   = 4'd1,
    OP_LOAD      = 4'd2,
    OP_RESTART   = 4'd3,
    OP_END       = 4'd4,
    OP_FETCH     = 4'd5,
    OP_EXEC      = 4'd6,
    OP_CELL_LOAD = 4'd7,
    OP_SCAN_RD   = 4'd8,
    OP_SCAN_CHK  = 4'd9,
    OP_UNMATCHED = 4'd10,
    OP_EMIT      = 4'd11
  } dp_op_e;

  // datapath flags seen by the controller
  typedef struct packed {
    req_e req;
    logic prog_end;
    logic need_tape_rd;
    logic jump_taken;
    logic scan_end;
    logic scan_match;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic valid;
    cmd_e code;
  } decoded_t;

  // character to stored command code
  function automatic decoded_t decode_char(input logic [7:0] ch);
    decoded_t d;
    d.valid = 1'b1;
    d.code  = CMD_RIGHT;
    case (ch)
      CHAR_RIGHT: d.code = CMD_RIGHT;
      CHAR_LEFT:  d.code = CMD_LEFT;
      CHAR_INC:   d.code = CMD_INC;
      CHAR_DEC:   d.code = CMD_DEC;
      CHAR_OUT:   d.code = CMD_OUT;
      CHAR_IN:    d.code = CMD_IN;
      CHAR_OPEN:  d.code = CMD_OPEN;
      CHAR_CLOSE: d.code = CMD_CLOSE;
      default:    d.valid = 1'b0;
    endcase
    return d;
  endfunction

  // stored code to executed command number 1..8
  function automatic logic [3:0] exec_code(input cmd_e c);
    return {1'b0, c} + 4'd1;
  endfunction

endpackage

// ----- rtl/bfs_if.sv -----
// ----------------------------------------------------------------------------
// bfs_req_if / bfs_rsp_if
// Valid/ready channels for requests into and results out of the core.
// ----------------------------------------------------------------------------
interface bfs_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] program_char;
  logic [7:0] input_char;

  modport source (output valid, req_type, program_char, input_char, input ready);
  modport sink (input valid, req_type, program_char, input_char, output ready);
endinterface

interface bfs_rsp_if #(
  parameter int unsigned PcW = $clog2(bfs_pkg::ProgDepthDefault + 1),
  parameter int unsigned DpW = $clog2(bfs_pkg::TapeDepthDefault)
);
  logic           valid;
  logic           ready;
  logic           out_valid;
  logic [7:0]     out_char;
  logic [3:0]     executed_cmd;
  logic [PcW-1:0] prog_counter;
  logic [DpW-1:0] tape_pointer;
  logic [7:0]     cell_value;
  logic [1:0]     status;

  modport source (output valid, out_valid, out_char, executed_cmd, prog_counter,
                  tape_pointer, cell_value, status, input ready);
  modport sink (input valid, out_valid, out_char, executed_cmd, prog_counter,
                tape_pointer, cell_value, status, output ready);
endinterface

// ----- rtl/bfs_ctrl.sv -----
// ----------------------------------------------------------------------------
// bfs_ctrl
// Sequencer: accepts a request, walks the datapath through its operations
// and hands the finished result to the output register.
// ----------------------------------------------------------------------------
module bfs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bfs_pkg::dp_status_t flags_i,
  output bfs_pkg::dp_op_e     op_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DISP = 7'b0000010,
    S_EXEC = 7'b0000100,
    S_TRD  = 7'b0001000,
    S_SRD  = 7'b0010000,
    S_SCHK = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // next state and operation
  always_comb begin
    state_d    = state_q;
    op_o       = bfs_pkg::OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_o    = bfs_pkg::OP_CAPTURE;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        case (flags_i.req)
          bfs_pkg::REQ_LOAD: begin
            op_o    = bfs_pkg::OP_LOAD;
            state_d = S_DONE;
          end
          bfs_pkg::REQ_STEP: begin
            if (flags_i.prog_end) begin
              op_o    = bfs_pkg::OP_END;
              state_d = S_DONE;
            end else begin
              op_o    = bfs_pkg::OP_FETCH;
              state_d = S_EXEC;
            end
          end
          default: begin
            op_o    = bfs_pkg::OP_RESTART;
            state_d = S_DONE;
          end
        endcase
      end
      S_EXEC: begin
        op_o = bfs_pkg::OP_EXEC;
        if (flags_i.need_tape_rd) begin
          state_d = S_TRD;
        end else if (flags_i.jump_taken) begin
          state_d = S_SRD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_TRD: begin
        op_o    = bfs_pkg::OP_CELL_LOAD;
        state_d = S_DONE;
      end
      S_SRD: begin
        if (flags_i.scan_end) begin
          op_o    = bfs_pkg::OP_UNMATCHED;
          state_d = S_DONE;
        end else begin
          op_o    = bfs_pkg::OP_SCAN_RD;
          state_d = S_SCHK;
        end
      end
      S_SCHK: begin
        op_o    = bfs_pkg::OP_SCAN_CHK;
        state_d = flags_i.scan_match ? S_DONE : S_SRD;
      end
      S_DONE: begin
        if (flags_i.out_free) begin
          op_o    = bfs_pkg::OP_EMIT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/bfs_datapath.sv -----
// ----------------------------------------------------------------------------
// bfs_datapath
// Program store, tape, pointers, bracket scan unit and output register.
// Tape cells outside the visited span read as zero; a cell is zeroed in
// memory when the pointer first steps onto it.
// ----------------------------------------------------------------------------
module bfs_datapath #(
  parameter int unsigned TAPE_DEPTH    = bfs_pkg::TapeDepthDefault,
  parameter int unsigned PROGRAM_DEPTH = bfs_pkg::ProgDepthDefault,
  localparam int unsigned PcW = $clog2(PROGRAM_DEPTH + 1),
  localparam int unsigned DpW = $clog2(TAPE_DEPTH)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bfs_pkg::dp_op_e     op_i,
  output bfs_pkg::dp_status_t flags_o,
  input  logic [1:0]          req_type_i,
  input  logic [7:0]          program_char_i,
  input  logic [7:0]          input_char_i,
  input  logic                rsp_ready_i,
  output logic                rsp_valid_o,
  output logic                out_valid_o,
  output logic [7:0]          out_char_o,
  output logic [3:0]          executed_cmd_o,
  output logic [PcW-1:0]      prog_counter_o,
  output logic [DpW-1:0]      tape_pointer_o,
  output logic [7:0]          cell_value_o,
  output logic [1:0]          status_o
);

  localparam int unsigned PaW  = $clog2(PROGRAM_DEPTH);
  localparam int unsigned CntW = $clog2(TAPE_DEPTH + 1);
  localparam logic [DpW-1:0]  TapeLast = DpW'(TAPE_DEPTH - 1);
  localparam logic [CntW-1:0] TapeCnt  = CntW'(TAPE_DEPTH);
  localparam logic [PcW-1:0]  ProgFull = PcW'(PROGRAM_DEPTH);

  // architectural state
  logic [PcW-1:0]  pc_q, len_q;
  logic [DpW-1:0]  dp_q;
  logic [7:0]      cell_q;
  logic [CntW-1:0] right_q, left_q;   // visited span: [0, right) and [end-left, end)
  logic            zero_ok_q;         // cell 0 written since restart

  // captured request
  bfs_pkg::req_e req_q;
  logic [7:0]    pchar_q, ichar_q;

  // scan unit
  logic [PcW-1:0] jdx_q, depth_q;
  logic           fwd_q;

  // per-item result
  logic                 res_outv_q;
  logic [7:0]           res_outc_q;
  logic [3:0]           res_exec_q;
  bfs_pkg::status_e     res_stat_q;

  // output register
  logic            out_vld_q;
  logic            o_outv_q;
  logic [7:0]      o_outc_q, o_cell_q;
  logic [3:0]      o_exec_q;
  logic [PcW-1:0]  o_pc_q;
  logic [DpW-1:0]  o_dp_q;
  logic [1:0]      o_stat_q;

  // memories
  logic [2:0] prog_mem [PROGRAM_DEPTH];
  logic [7:0] tape_mem [TAPE_DEPTH];
  logic [2:0] prog_rdata_q;
  logic [7:0] tape_rdata_q;

  logic           prog_we, prog_re, tape_we, tape_re;
  logic [PaW-1:0] prog_waddr, prog_raddr;
  logic [2:0]     prog_wdata;
  logic [DpW-1:0] tape_waddr;
  logic [7:0]     tape_wdata;

  bfs_pkg::cmd_e    code;
  bfs_pkg::decoded_t dec;
  logic [DpW-1:0]   dp_inc, dp_dec, nd;
  logic             is_move, is_cellop, fresh, cell_zero, prog_full;
  logic [7:0]       cell_new;
  logic [PcW-1:0]   pc_inc, scan_addr;
  bfs_pkg::cmd_e    open_like, close_like;

  // decode and move targets
  always_comb begin
    code      = bfs_pkg::cmd_e'(prog_rdata_q);
    dec       = bfs_pkg::decode_char(pchar_q);
    prog_full = (len_q == ProgFull);
    pc_inc    = pc_q + PcW'(1);
    dp_inc    = (dp_q == TapeLast) ? '0 : dp_q + DpW'(1);
    dp_dec    = (dp_q == '0) ? TapeLast : dp_q - DpW'(1);
    nd        = (code == bfs_pkg::CMD_LEFT) ? dp_dec : dp_inc;
    is_move   = (code == bfs_pkg::CMD_RIGHT) || (code == bfs_pkg::CMD_LEFT);
    is_cellop = (code == bfs_pkg::CMD_INC) || (code == bfs_pkg::CMD_DEC) ||
                (code == bfs_pkg::CMD_IN);
    fresh     = !((CntW'(nd) < right_q) || (CntW'(nd) >= TapeCnt - left_q));
    cell_zero = (cell_q == 8'd0);
    case (code)
      bfs_pkg::CMD_INC: cell_new = cell_q + 8'd1;
      bfs_pkg::CMD_DEC: cell_new = cell_q - 8'd1;
      default:          cell_new = ichar_q;
    endcase
    // bracket roles depend on scan direction
    open_like  = fwd_q ? bfs_pkg::CMD_OPEN : bfs_pkg::CMD_CLOSE;
    close_like = fwd_q ? bfs_pkg::CMD_CLOSE : bfs_pkg::CMD_OPEN;
    scan_addr  = fwd_q ? jdx_q : jdx_q - PcW'(1);
  end

  // flags to the controller
  always_comb begin
    flags_o.req          = req_q;
    flags_o.prog_end     = (pc_q >= len_q);
    flags_o.need_tape_rd = is_move && !fresh;
    flags_o.jump_taken   = ((code == bfs_pkg::CMD_OPEN) && cell_zero) ||
                           ((code == bfs_pkg::CMD_CLOSE) && !cell_zero);
    flags_o.scan_end     = fwd_q ? (jdx_q >= len_q) : (jdx_q == '0);
    flags_o.scan_match   = (depth_q == '0) && (code == close_like);
    flags_o.out_free     = !out_vld_q || rsp_ready_i;
  end

  // memory port control
  always_comb begin
    prog_we    = (op_i == bfs_pkg::OP_LOAD) && dec.valid && !prog_full;
    prog_waddr = len_q[PaW-1:0];
    prog_wdata = dec.code;
    prog_re    = (op_i == bfs_pkg::OP_FETCH) || (op_i == bfs_pkg::OP_SCAN_RD);
    prog_raddr = (op_i == bfs_pkg::OP_FETCH) ? pc_q[PaW-1:0] : scan_addr[PaW-1:0];
    tape_we    = (op_i == bfs_pkg::OP_EXEC) && ((is_move && fresh) || is_cellop);
    tape_waddr = is_move ? nd : dp_q;
    tape_wdata = is_move ? 8'd0 : cell_new;
    tape_re    = (op_i == bfs_pkg::OP_EXEC) && is_move && !fresh;
  end

  // program store
  always_ff @(posedge clk_i) begin
    if (prog_we) begin
      prog_mem[prog_waddr] <= prog_wdata;
    end
    if (prog_re) begin
      prog_rdata_q <= prog_mem[prog_raddr];
    end
  end

  // tape
  always_ff @(posedge clk_i) begin
    if (tape_we) begin
      tape_mem[tape_waddr] <= tape_wdata;
    end
    if (tape_re) begin
      tape_rdata_q <= tape_mem[nd];
    end
  end

  // pointers, length, current cell, visited span, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q      <= '0;
      len_q     <= '0;
      dp_q      <= '0;
      cell_q    <= 8'd0;
      right_q   <= CntW'(1);
      left_q    <= '0;
      zero_ok_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (out_vld_q && rsp_ready_i) begin
        out_vld_q <= 1'b0;
      end
      case (op_i)
        bfs_pkg::OP_LOAD: begin
          if (prog_we) begin
            len_q <= len_q + PcW'(1);
          end
        end
        bfs_pkg::OP_RESTART: begin
          pc_q      <= '0;
          dp_q      <= '0;
          cell_q    <= 8'd0;
          right_q   <= CntW'(1);
          left_q    <= '0;
          zero_ok_q <= 1'b0;
          if (req_q == bfs_pkg::REQ_CLEAR) begin
            len_q <= '0;
          end
        end
        bfs_pkg::OP_EXEC: begin
          if (is_move) begin
            dp_q <= nd;
            pc_q <= pc_inc;
            if (fresh) begin
              cell_q <= 8'd0;
              if (code == bfs_pkg::CMD_RIGHT) begin
                right_q <= right_q + CntW'(1);
              end else begin
                left_q <= left_q + CntW'(1);
              end
            end
          end else if (is_cellop) begin
            cell_q <= cell_new;
            pc_q   <= pc_inc;
            if (dp_q == '0) begin
              zero_ok_q <= 1'b1;
            end
          end else if (!flags_o.jump_taken) begin
            pc_q <= pc_inc;
          end
        end
        bfs_pkg::OP_CELL_LOAD: begin
          cell_q <= ((dp_q == '0) && !zero_ok_q) ? 8'd0 : tape_rdata_q;
        end
        bfs_pkg::OP_SCAN_CHK: begin
          if (flags_o.scan_match) begin
            pc_q <= jdx_q + PcW'(1);
          end
        end
        bfs_pkg::OP_EMIT: begin
          out_vld_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // request capture, scan unit, result fields, output payload
  always_ff @(posedge clk_i) begin
    case (op_i)
      bfs_pkg::OP_CAPTURE: begin
        req_q      <= bfs_pkg::req_e'(req_type_i);
        pchar_q    <= program_char_i;
        ichar_q    <= input_char_i;
        res_outv_q <= 1'b0;
        res_outc_q <= 8'd0;
        res_exec_q <= bfs_pkg::EXEC_NONE;
        res_stat_q <= bfs_pkg::ST_OK;
      end
      bfs_pkg::OP_LOAD: begin
        if (dec.valid && prog_full) begin
          res_stat_q <= bfs_pkg::ST_FULL;
        end
      end
      bfs_pkg::OP_END: res_stat_q <= bfs_pkg::ST_END;
      bfs_pkg::OP_EXEC: begin
        if (flags_o.jump_taken) begin
          fwd_q   <= (code == bfs_pkg::CMD_OPEN);
          jdx_q   <= (code == bfs_pkg::CMD_OPEN) ? pc_inc : pc_q;
          depth_q <= '0;
        end else begin
          res_exec_q <= bfs_pkg::exec_code(code);
        end
        if (code == bfs_pkg::CMD_OUT) begin
          res_outv_q <= 1'b1;
          res_outc_q <= cell_q;
        end
      end
      bfs_pkg::OP_SCAN_RD: begin
        if (!fwd_q) begin
          jdx_q <= jdx_q - PcW'(1);
        end
      end
      bfs_pkg::OP_SCAN_CHK: begin
        if (flags_o.scan_match) begin
          res_exec_q <= bfs_pkg::exec_code(open_like);
        end else begin
          if (code == open_like) begin
            depth_q <= depth_q + PcW'(1);
          end else if (code == close_like) begin
            depth_q <= depth_q - PcW'(1);
          end
          if (fwd_q) begin
            jdx_q <= jdx_q + PcW'(1);
          end
        end
      end
      bfs_pkg::OP_UNMATCHED: res_stat_q <= bfs_pkg::ST_UNMATCHED;
      bfs_pkg::OP_EMIT: begin
        o_outv_q <= res_outv_q;
        o_outc_q <= res_outc_q;
        o_exec_q <= res_exec_q;
        o_pc_q   <= pc_q;
        o_dp_q   <= dp_q;
        o_cell_q <= cell_q;
        o_stat_q <= res_stat_q;
      end
      default: ;
    endcase
  end

  assign rsp_valid_o    = out_vld_q;
  assign out_valid_o    = o_outv_q;
  assign out_char_o     = o_outc_q;
  assign executed_cmd_o = o_exec_q;
  assign prog_counter_o = o_pc_q;
  assign tape_pointer_o = o_dp_q;
  assign cell_value_o   = o_cell_q;
  assign status_o       = o_stat_q;

`ifndef NO_ASSERTIONS
  // visited span never exceeds the tape
  a_span_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, right_q} + {1'b0, left_q}) <= {1'b0, TapeCnt})
    else $error("visited span exceeds tape");

  // next command never runs past the stored program
  a_pc_in_prog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= len_q)
    else $error("program counter past program length");

  // data pointer stays on the tape
  a_dp_on_tape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CntW'(dp_q) < TapeCnt)
    else $error("data pointer off tape");

  // a result is only loaded into a free output register
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == bfs_pkg::OP_EMIT) |-> (!out_vld_q || rsp_ready_i))
    else $error("result overwrote pending beat");

  // restart leaves pointers and cell cleared
  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == bfs_pkg::OP_RESTART) |=> (pc_q == '0 && dp_q == '0 && cell_q == 8'd0))
    else $error("restart did not clear state");
`endif

endmodule

// ----- rtl/brainfuck_step_core.sv -----
// ----------------------------------------------------------------------------
// brainfuck_step_core
// Stepping core for the eight-command tape language: loads program
// characters, executes one command per step, restarts and clears.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake                 beat contents
//   req_i    in   req_i.valid / req_i.ready  req_type, program_char, input_char
//   rsp_o    out  rsp_o.valid / rsp_o.ready  out_valid, out_char, executed_cmd,
//                                            prog_counter, tape_pointer,
//                                            cell_value, status
//
// One result beat per request. Load, restart, clear and a step past the end
// pass capture, dispatch and done states; a plain command adds an execute
// state, a move onto an already visited cell also a tape read. A taken bracket
// jump adds a program read and check per entry scanned (and an end check when
// no match is found), paced by the single registered read port of the program
// store. Reset needs no clearing pass: tape cells outside the visited span read
// as zero. A new request is accepted while the previous result beat still
// waits; the core then holds its next result until the output register frees up.
//
module brainfuck_step_core #(
  parameter int unsigned TAPE_DEPTH    = bfs_pkg::TapeDepthDefault,
  parameter int unsigned PROGRAM_DEPTH = bfs_pkg::ProgDepthDefault
) (
  input logic         clk_i,
  input logic         rst_ni,
  bfs_req_if.sink     req_i,
  bfs_rsp_if.source   rsp_o
);

  localparam int unsigned PcW = $clog2(PROGRAM_DEPTH + 1);
  localparam int unsigned DpW = $clog2(TAPE_DEPTH);

  bfs_pkg::dp_op_e     op;
  bfs_pkg::dp_status_t flags;
  logic                in_ready;
  logic [PcW-1:0]      prog_counter;
  logic [DpW-1:0]      tape_pointer;

  // sequencer
  bfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .flags_i    (flags),
    .op_o       (op)
  );

  // stores, pointers and output register
  bfs_datapath #(
    .TAPE_DEPTH    (TAPE_DEPTH),
    .PROGRAM_DEPTH (PROGRAM_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op),
    .flags_o        (flags),
    .req_type_i     (req_i.req_type),
    .program_char_i (req_i.program_char),
    .input_char_i   (req_i.input_char),
    .rsp_ready_i    (rsp_o.ready),
    .rsp_valid_o    (rsp_o.valid),
    .out_valid_o    (rsp_o.out_valid),
    .out_char_o     (rsp_o.out_char),
    .executed_cmd_o (rsp_o.executed_cmd),
    .prog_counter_o (prog_counter),
    .tape_pointer_o (tape_pointer),
    .cell_value_o   (rsp_o.cell_value),
    .status_o       (rsp_o.status)
  );

  assign req_i.ready        = in_ready;
  assign rsp_o.prog_counter = prog_counter;
  assign rsp_o.tape_pointer = tape_pointer;

endmodule
